// ===== rtl/pwm_duty_frequency_meter_top_macros.svh =====
// Assertion macros for the PWM duty/frequency meter.
// Included by pwm_duty_frequency_meter_top.sv; no other dependencies.
`ifndef PWM_DUTY_FREQUENCY_METER_TOP_MACROS_SVH
`define PWM_DUTY_FREQUENCY_METER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PDFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PDFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdfm_pkg.sv =====
// Shared types and constants for the PWM duty/frequency meter.
// No dependencies; imported by pdfm_div and pwm_duty_frequency_meter_top.
package pdfm_pkg;

    localparam int TIME_W    = 16;
    localparam int TICK_W    = 27;
    localparam int DUTY_W    = 14;
    localparam int DIV_W     = 30;   // dividend width: 16b high ticks * 10000 < 2^30
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(10000);
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);

    typedef enum logic [1:0] {
        PH_RISE1 = 2'd0,
        PH_FALL  = 2'd1,
        PH_RISE2 = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DUTY,
        ST_DUTY_WAIT,
        ST_FREQ,
        ST_FREQ_WAIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [TIME_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } t_div_rsp;

endpackage

// ===== rtl/pdfm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by duty and frequency.
// Depends on pdfm_pkg (widths and request/response structs).
module pdfm_div
    import pdfm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [TIME_W-1:0]    r_rem, n_rem;
    logic [TIME_W-1:0]    r_div, n_div;

    logic [TIME_W:0]      partial;
    logic [TIME_W+1:0]    trial;
    logic                 borrow;

    // partial remainder always below the divisor, so 17 bits hold the shifted value
    assign partial = {r_rem, r_quo[DIV_W-1]};
    assign trial   = {1'b0, partial} - {2'b00, r_div};
    assign borrow  = trial[TIME_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_W);
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = borrow ? partial[TIME_W-1:0] : trial[TIME_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ~borrow};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/pwm_duty_frequency_meter_top.sv =====
// PWM duty/frequency meter. Each input transaction is one captured counter value at the
// armed edge (rise, fall, rise). Rise and fall edges load their result into the output
// register at the accepting edge. The second rise of a measurement with a nonzero period
// runs a multiply state, then two 30-step passes of the shared restoring divider (duty,
// then frequency), each with one launch state and one wait state that takes its quotient
// (the last one loads the result). A high width not below the period saturates the duty
// and skips its pass; a zero period loads its result at the accepting edge. Input ready
// is low while the sequencer runs and while an unaccepted result would be overwritten.
// Depends on pdfm_pkg, pdfm_div and pwm_duty_frequency_meter_top_macros.svh.
`include "pwm_duty_frequency_meter_top_macros.svh"

module pwm_duty_frequency_meter_top
    import pdfm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICK_W-1:0]  i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [TIME_W-1:0]  i_capture_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_armed_edge,
    output logic               o_measure_done,
    output logic [TIME_W-1:0]  o_high_ticks,
    output logic [TIME_W-1:0]  o_period_ticks,
    output logic [DUTY_W-1:0]  o_duty_hundredths,
    output logic [TICK_W-1:0]  o_frequency_hz,
    output logic               o_zero_period
);

    localparam int CapW = (COUNTER_BITS < TIME_W) ? COUNTER_BITS : TIME_W;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [CapW-1:0]    r_first_rise, n_first_rise;
    logic [TIME_W-1:0]  r_high_width, n_high_width;
    logic [TIME_W-1:0]  r_hi, n_hi;
    logic [TIME_W-1:0]  r_per, n_per;
    logic [DIV_W-1:0]   r_prod, n_prod;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic [TICK_W-1:0]  r_tick_rate;

    logic               r_out_valid, n_out_valid;
    logic               r_o_armed, n_o_armed;
    logic               r_o_done, n_o_done;
    logic [TIME_W-1:0]  r_o_hi, n_o_hi;
    logic [TIME_W-1:0]  r_o_per, n_o_per;
    logic [DUTY_W-1:0]  r_o_duty, n_o_duty;
    logic [TICK_W-1:0]  r_o_freq, n_o_freq;
    logic               r_o_zp, n_o_zp;

    logic               in_accept;
    logic               out_load;
    logic [CapW-1:0]    now_w;
    logic [CapW-1:0]    diff_w;
    logic [TIME_W-1:0]  diff16;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    pdfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    // differences wrap at the counter width
    assign now_w  = i_capture_time[CapW-1:0];
    assign diff_w = now_w - r_first_rise;
    assign diff16 = TIME_W'(diff_w);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_first_rise = r_first_rise;
        n_high_width = r_high_width;
        n_hi         = r_hi;
        n_per        = r_per;
        n_prod       = r_prod;
        n_duty       = r_duty;
        out_load     = 1'b0;
        n_o_armed    = r_o_armed;
        n_o_done     = r_o_done;
        n_o_hi       = r_o_hi;
        n_o_per      = r_o_per;
        n_o_duty     = r_o_duty;
        n_o_freq     = r_o_freq;
        n_o_zp       = r_o_zp;
        div_req.start    = 1'b0;
        div_req.dividend = (r_state == ST_DUTY) ? r_prod : DIV_W'(r_tick_rate);
        div_req.divisor  = r_per;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (r_phase)
                        PH_FALL: begin
                            n_high_width = diff16;
                            n_phase      = PH_RISE2;
                            out_load     = 1'b1;
                            n_o_armed    = 1'b0;
                            n_o_done     = 1'b0;
                            n_o_hi       = '0;
                            n_o_per      = '0;
                            n_o_duty     = '0;
                            n_o_freq     = '0;
                            n_o_zp       = 1'b0;
                        end
                        PH_RISE2: begin
                            n_phase = PH_RISE1;
                            n_hi    = r_high_width;
                            n_per   = diff16;
                            if (diff16 == '0) begin
                                out_load  = 1'b1;
                                n_o_armed = 1'b0;
                                n_o_done  = 1'b1;
                                n_o_hi    = r_high_width;
                                n_o_per   = '0;
                                n_o_duty  = '0;
                                n_o_freq  = '0;
                                n_o_zp    = 1'b1;
                            end else begin
                                n_state = ST_MUL;
                            end
                        end
                        default: begin
                            // first rise; the unused phase code behaves the same
                            n_first_rise = now_w;
                            n_phase      = PH_FALL;
                            out_load     = 1'b1;
                            n_o_armed    = 1'b1;
                            n_o_done     = 1'b0;
                            n_o_hi       = '0;
                            n_o_per      = '0;
                            n_o_duty     = '0;
                            n_o_freq     = '0;
                            n_o_zp       = 1'b0;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_prod = DIV_W'(r_hi) * DIV_W'(DUTY_FULL);
                // high >= period means quotient >= 10000: saturate, skip the duty divide
                if (r_hi >= r_per) begin
                    n_duty  = DUTY_FULL;
                    n_state = ST_FREQ;
                end else begin
                    n_state = ST_DUTY;
                end
            end
            ST_DUTY: begin
                div_req.start = 1'b1;
                n_state       = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT: begin
                if (div_rsp.done) begin
                    n_duty  = div_rsp.quotient[DUTY_W-1:0];
                    n_state = ST_FREQ;
                end
            end
            ST_FREQ: begin
                div_req.start = 1'b1;
                n_state       = ST_FREQ_WAIT;
            end
            ST_FREQ_WAIT: begin
                if (div_rsp.done) begin
                    out_load  = 1'b1;
                    n_o_armed = 1'b0;
                    n_o_done  = 1'b1;
                    n_o_hi    = r_hi;
                    n_o_per   = r_per;
                    n_o_duty  = r_duty;
                    n_o_freq  = div_rsp.quotient[TICK_W-1:0];
                    n_o_zp    = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = out_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_RISE1;
            r_first_rise <= '0;
            r_high_width <= '0;
            r_out_valid  <= 1'b0;
            r_tick_rate  <= TICK_RESET;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_first_rise <= n_first_rise;
            r_high_width <= n_high_width;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_tick_rate <= i_cfg_data;
            end
        end
        r_hi      <= n_hi;
        r_per     <= n_per;
        r_prod    <= n_prod;
        r_duty    <= n_duty;
        r_o_armed <= n_o_armed;
        r_o_done  <= n_o_done;
        r_o_hi    <= n_o_hi;
        r_o_per   <= n_o_per;
        r_o_duty  <= n_o_duty;
        r_o_freq  <= n_o_freq;
        r_o_zp    <= n_o_zp;
    end

    assign o_out_valid       = r_out_valid;
    assign o_armed_edge      = r_o_armed;
    assign o_measure_done    = r_o_done;
    assign o_high_ticks      = r_o_hi;
    assign o_period_ticks    = r_o_per;
    assign o_duty_hundredths = r_o_duty;
    assign o_frequency_hz    = r_o_freq;
    assign o_zero_period     = r_o_zp;

    `PDFM_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n,
        r_state != ST_IDLE, !o_in_ready, "ready while sequencer busy")
    `PDFM_ASSERT_NOW(a_finish_slot_free, i_clk, i_rst_n,
        (r_state == ST_FREQ_WAIT) && div_rsp.done, !r_out_valid,
        "result register occupied at measurement finish")
    `PDFM_ASSERT_NEXT(a_long_path_start, i_clk, i_rst_n,
        in_accept && (r_phase == PH_RISE2) && (diff16 != '0), r_state == ST_MUL,
        "nonzero period did not start the multiply")
    `PDFM_ASSERT_NOW(a_zero_period_out, i_clk, i_rst_n,
        o_out_valid && o_zero_period,
        (o_duty_hundredths == '0) && (o_frequency_hz == '0) && o_measure_done,
        "zero period result carries duty or frequency")

endmodule
